### design/gacs_pkg.sv
// shared constants and types for the gamepad axis calibrate/scale block
// register indexes, opcodes, scale factors and the divider status struct
// no dependencies
`default_nettype none

package gacs_pkg;

	// default sizes of the block
	localparam int CAL_COUNT_DEF    = 32;
	localparam int BUTTON_COUNT_DEF = 4;
	localparam int AXIS_BITS_DEF    = 16;

	// fixed field widths
	localparam int ID_W      = 8;
	localparam int DZ_W      = 8;
	localparam int OUT_W     = 8;
	localparam int REG_IDX_W = 3;
	localparam int NUM_AXES  = 2;
	localparam int AXIS_X    = 0;
	localparam int AXIS_Y    = 1;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_BOUND_ID = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_MAX    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_MIN    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_Y_MAX    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DEAD     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BTN_MASK = 3'd6;

	// reset value of the axis maxima
	localparam int RESET_MAX = 255;

	// item opcodes
	localparam logic OP_DECODE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// output scale factors above and below the centre
	localparam int SCALE_UP   = 127;
	localparam int SCALE_DOWN = 128;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### design/gamepad_axis_calibrate_scale.sv
// gamepad axis calibration and scaling, top level
// holds the configuration registers, the item sequencer and two gacs_div units
// depends on gacs_pkg and gacs_div
`default_nettype none

// Takes one extracted report per transfer and returns one result per transfer.
// After reset or a restart item the block averages the axes over CAL_COUNT
// matching reports and then scales each axis to -128..127 around that centre.
// A restart item, a report with a foreign id or a report taken during
// calibration (but the last) goes from the decode state straight to the
// output state. Any other report passes through the set-up states S_PREP1
// and S_PREP2 and a bit-serial restoring divider per axis; the last
// calibration report uses the same dividers for the centre average. The
// next item is taken once the result has moved to the output register,
// even while that result is still waiting to be taken.
module gamepad_axis_calibrate_scale #(
	parameter int CAL_COUNT    = gacs_pkg::CAL_COUNT_DEF,
	parameter int BUTTON_COUNT = gacs_pkg::BUTTON_COUNT_DEF,
	parameter int AXIS_BITS    = gacs_pkg::AXIS_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_wr_en,
	input  wire logic [gacs_pkg::REG_IDX_W-1:0]           cfg_index,
	input  wire logic [((AXIS_BITS > gacs_pkg::ID_W) ? AXIS_BITS : gacs_pkg::ID_W)-1:0]
	                                                      cfg_wdata,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic                                     opcode,
	input  wire logic [gacs_pkg::ID_W-1:0]                report_id,
	input  wire logic signed [AXIS_BITS-1:0]              raw_x,
	input  wire logic                                     x_valid,
	input  wire logic signed [AXIS_BITS-1:0]              raw_y,
	input  wire logic                                     y_valid,
	input  wire logic [BUTTON_COUNT-1:0]                  button_bits,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic                                          accepted,
	output logic signed [gacs_pkg::OUT_W-1:0]             axis_x_out,
	output logic signed [gacs_pkg::OUT_W-1:0]             axis_y_out,
	output logic [BUTTON_COUNT-1:0]                       buttons_out,
	output logic                                          in_calibration
);
	import gacs_pkg::*;

	localparam int AB    = AXIS_BITS;
	localparam int NUM_W = AXIS_BITS + 8;
	localparam int DEN_W = AXIS_BITS + 1;
	localparam int QUO_W = AXIS_BITS + 1;
	localparam int SUM_W = AXIS_BITS + $clog2(CAL_COUNT);
	localparam int CNT_W = $clog2(CAL_COUNT + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PREP1,
		S_PREP2,
		S_START,
		S_DIV,
		S_POST,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [ID_W-1:0]          bound_id_q;
	logic signed [AB-1:0]     lo_q [NUM_AXES];
	logic signed [AB-1:0]     hi_q [NUM_AXES];
	logic [DZ_W-1:0]          dz_q;
	logic [BUTTON_COUNT-1:0]  mask_q;

	// calibration state
	logic                     calibrating_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q [NUM_AXES];
	logic signed [AB-1:0]     centre_q [NUM_AXES];
	logic                     centre_set_q [NUM_AXES];
	logic                     cal_mode_q;

	// latched item and work registers
	logic                     op_q;
	logic                     id_match_q;
	logic signed [AB-1:0]     raw_q [NUM_AXES];
	logic                     val_q [NUM_AXES];
	logic [BUTTON_COUNT-1:0]  btn_q;
	logic signed [AB-1:0]     rc_q [NUM_AXES];
	logic signed [AB-1:0]     ctr_q [NUM_AXES];
	logic                     empty_q [NUM_AXES];
	logic                     ge_q [NUM_AXES];
	logic [AB:0]              diff_q [NUM_AXES];
	logic [AB:0]              span_q [NUM_AXES];
	logic                     zero_q [NUM_AXES];
	logic                     neg_q [NUM_AXES];

	// staged result and output register
	logic                     res_acc_q;
	logic [OUT_W-1:0]         res_ax_q [NUM_AXES];
	logic [BUTTON_COUNT-1:0]  res_btn_q;
	logic                     res_cal_q;
	logic                     out_valid_q;
	logic                     out_acc_q;
	logic [OUT_W-1:0]         out_x_q;
	logic [OUT_W-1:0]         out_y_q;
	logic [BUTTON_COUNT-1:0]  out_btn_q;
	logic                     out_cal_q;

	// combinational helpers
	logic                     in_xfer;
	logic                     out_free;
	logic [CNT_W-1:0]         cnt_next;
	logic                     cal_last;
	logic signed [SUM_W-1:0]  sum_next [NUM_AXES];
	logic [SUM_W-1:0]         sum_mag [NUM_AXES];
	logic [AB:0]              hl_diff [NUM_AXES];
	logic [AB-1:0]            mid [NUM_AXES];
	logic signed [AB-1:0]     rc_next [NUM_AXES];
	logic [AB:0]              diff_next [NUM_AXES];
	logic [AB:0]              span_up [NUM_AXES];
	logic [AB:0]              span_dn [NUM_AXES];
	logic [AB:0]              diff_neg [NUM_AXES];
	logic [AB-1:0]            mag [NUM_AXES];
	logic [NUM_W-1:0]         scaled [NUM_AXES];
	logic [QUO_W-1:0]         quo_neg [NUM_AXES];
	logic [AB-1:0]            centre_new [NUM_AXES];
	logic [OUT_W-1:0]         lim [NUM_AXES];
	logic [OUT_W-1:0]         ax_val [NUM_AXES];

	// divider ports
	logic                     div_start;
	logic [NUM_W-1:0]         div_num [NUM_AXES];
	logic [DEN_W-1:0]         div_den [NUM_AXES];
	logic [QUO_W-1:0]         div_quo [NUM_AXES];
	div_stat_t                div_stat [NUM_AXES];

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_next  = cnt_q + CNT_W'(1);
	assign cal_last  = (cnt_next == CNT_W'(CAL_COUNT));
	assign div_start = (state_q == S_START);

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			sum_next[a] = sum_q[a] + (val_q[a] ? SUM_W'(raw_q[a]) : '0);
			sum_mag[a]  = sum_q[a][SUM_W-1] ? (~sum_q[a] + 1'b1) : sum_q[a];

			// range midpoint, (hi - lo) is positive whenever it is used
			hl_diff[a] = {hi_q[a][AB-1], hi_q[a]} - {lo_q[a][AB-1], lo_q[a]};
			mid[a]     = lo_q[a] + hl_diff[a][AB:1];
			if (raw_q[a] < lo_q[a])
				rc_next[a] = lo_q[a];
			else if (raw_q[a] > hi_q[a])
				rc_next[a] = hi_q[a];
			else
				rc_next[a] = raw_q[a];

			diff_next[a] = {rc_q[a][AB-1], rc_q[a]} - {ctr_q[a][AB-1], ctr_q[a]};
			span_up[a]   = {hi_q[a][AB-1], hi_q[a]} - {ctr_q[a][AB-1], ctr_q[a]};
			span_dn[a]   = {ctr_q[a][AB-1], ctr_q[a]} - {lo_q[a][AB-1], lo_q[a]};

			diff_neg[a] = (AB+1)'(0) - diff_q[a];
			mag[a]      = ge_q[a] ? diff_q[a][AB-1:0] : diff_neg[a][AB-1:0];
			scaled[a]   = ge_q[a] ? NUM_W'(mag[a]) * NUM_W'(SCALE_UP)
			                      : NUM_W'(mag[a]) * NUM_W'(SCALE_DOWN);
			div_num[a]  = cal_mode_q ? NUM_W'(sum_mag[a]) : scaled[a];
			div_den[a]  = cal_mode_q ? DEN_W'(CAL_COUNT) : DEN_W'(span_q[a][AB-1:0]);

			quo_neg[a]    = QUO_W'(0) - div_quo[a];
			centre_new[a] = sum_q[a][SUM_W-1] ? quo_neg[a][AB-1:0] : div_quo[a][AB-1:0];

			if (neg_q[a])
				lim[a] = (div_quo[a] > QUO_W'(SCALE_DOWN)) ? OUT_W'(SCALE_DOWN)
				                                           : OUT_W'(div_quo[a]);
			else
				lim[a] = (div_quo[a] > QUO_W'(SCALE_UP)) ? OUT_W'(SCALE_UP)
				                                         : OUT_W'(div_quo[a]);
			if (zero_q[a] || (lim[a] < dz_q))
				ax_val[a] = '0;
			else
				ax_val[a] = neg_q[a] ? (OUT_W'(0) - lim[a]) : lim[a];
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
		gacs_div #(
			.NUM_W(NUM_W),
			.DEN_W(DEN_W),
			.QUO_W(QUO_W)
		) u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (div_start),
			.num   (div_num[a]),
			.den   (div_den[a]),
			.quo   (div_quo[a]),
			.stat  (div_stat[a])
		);
	end

	// sequencer, configuration, calibration state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bound_id_q    <= '0;
			dz_q          <= '0;
			mask_q        <= '0;
			calibrating_q <= 1'b1;
			cnt_q         <= '0;
			cal_mode_q    <= 1'b0;
			res_acc_q     <= 1'b0;
			res_btn_q     <= '0;
			res_cal_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_acc_q     <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_btn_q     <= '0;
			out_cal_q     <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				lo_q[a]         <= '0;
				hi_q[a]         <= AB'(RESET_MAX);
				sum_q[a]        <= '0;
				centre_q[a]     <= '0;
				centre_set_q[a] <= 1'b0;
				res_ax_q[a]     <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BOUND_ID: bound_id_q     <= cfg_wdata[ID_W-1:0];
					REG_X_MIN:    lo_q[AXIS_X]   <= cfg_wdata[AB-1:0];
					REG_X_MAX:    hi_q[AXIS_X]   <= cfg_wdata[AB-1:0];
					REG_Y_MIN:    lo_q[AXIS_Y]   <= cfg_wdata[AB-1:0];
					REG_Y_MAX:    hi_q[AXIS_Y]   <= cfg_wdata[AB-1:0];
					REG_DEAD:     dz_q           <= cfg_wdata[DZ_W-1:0];
					REG_BTN_MASK: mask_q         <= cfg_wdata[BUTTON_COUNT-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_xfer)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					res_acc_q <= 1'b0;
					res_btn_q <= '0;
					for (int a = 0; a < NUM_AXES; a++)
						res_ax_q[a] <= '0;
					if (op_q == OP_RESTART) begin
						calibrating_q <= 1'b1;
						cnt_q         <= '0;
						for (int a = 0; a < NUM_AXES; a++)
							sum_q[a] <= '0;
						res_cal_q <= 1'b1;
						state_q   <= S_OUT;
					end else if (!id_match_q) begin
						res_cal_q <= calibrating_q;
						state_q   <= S_OUT;
					end else if (calibrating_q) begin
						for (int a = 0; a < NUM_AXES; a++)
							sum_q[a] <= sum_next[a];
						if (cal_last) begin
							// average goes through the dividers
							cnt_q      <= '0;
							cal_mode_q <= 1'b1;
							state_q    <= S_START;
						end else begin
							cnt_q     <= cnt_next;
							res_acc_q <= 1'b1;
							res_btn_q <= btn_q & mask_q;
							res_cal_q <= 1'b1;
							state_q   <= S_OUT;
						end
					end else begin
						cal_mode_q <= 1'b0;
						state_q    <= S_PREP1;
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat[AXIS_X].done)
						state_q <= S_POST;
				end
				S_POST: begin
					res_acc_q <= 1'b1;
					res_btn_q <= btn_q & mask_q;
					res_cal_q <= 1'b0;
					if (cal_mode_q) begin
						calibrating_q <= 1'b0;
						for (int a = 0; a < NUM_AXES; a++) begin
							res_ax_q[a] <= '0;
							if (val_q[a]) begin
								centre_q[a]     <= centre_new[a];
								centre_set_q[a] <= 1'b1;
							end
						end
					end else begin
						for (int a = 0; a < NUM_AXES; a++)
							res_ax_q[a] <= ax_val[a];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= res_acc_q;
						out_x_q     <= res_ax_q[AXIS_X];
						out_y_q     <= res_ax_q[AXIS_Y];
						out_btn_q   <= res_btn_q;
						out_cal_q   <= res_cal_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item latch and per-axis set-up registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q          <= opcode;
			id_match_q    <= (report_id == bound_id_q);
			raw_q[AXIS_X] <= raw_x;
			raw_q[AXIS_Y] <= raw_y;
			val_q[AXIS_X] <= x_valid;
			val_q[AXIS_Y] <= y_valid;
			btn_q         <= button_bits;
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			if (state_q == S_PREP1) begin
				rc_q[a]    <= rc_next[a];
				ctr_q[a]   <= centre_set_q[a] ? centre_q[a] : mid[a];
				empty_q[a] <= (hi_q[a] <= lo_q[a]);
			end
			if (state_q == S_PREP2) begin
				ge_q[a]   <= (rc_q[a] >= ctr_q[a]);
				diff_q[a] <= diff_next[a];
				span_q[a] <= (rc_q[a] >= ctr_q[a]) ? span_up[a] : span_dn[a];
			end
			if (state_q == S_START) begin
				// span at or below zero, empty range or missing axis read zero
				zero_q[a] <= empty_q[a] || !val_q[a] || span_q[a][AB]
				             || (span_q[a] == '0);
				neg_q[a]  <= !ge_q[a];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = out_acc_q;
	assign axis_x_out     = out_x_q;
	assign axis_y_out     = out_y_q;
	assign buttons_out    = out_btn_q;
	assign in_calibration = out_cal_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat[AXIS_X].done == div_stat[AXIS_Y].done)
		else $error("axis dividers out of step");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat[AXIS_X].busy || div_stat[AXIS_X].done))
		else $error("waiting on an idle divider");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output state");

	a_cal_axes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_calibration) |-> (axis_x_out == '0 && axis_y_out == '0))
		else $error("axis value shown while calibrating");

	a_centre_kept: assert property (@(posedge clk) disable iff (!arst_n)
		centre_set_q[AXIS_X] |=> centre_set_q[AXIS_X])
		else $error("calibrated centre lost");

endmodule

`default_nettype wire

### design/gacs_div.sv
// restoring divider, one quotient bit per cycle
// unsigned num / den, needs num < den * 2**QUO_W
// depends on gacs_pkg for the status struct
`default_nettype none

module gacs_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 17,
	parameter int QUO_W = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_W-1:0]    num,
	input  wire logic [DEN_W-1:0]    den,
	output logic [QUO_W-1:0]         quo,
	output gacs_pkg::div_stat_t      stat
);
	import gacs_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;

	// next partial remainder with the next numerator bit brought down
	assign trial     = {rem_q, num_q[QUO_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// upper numerator bits are known to be below the divisor
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			num_q <= num[QUO_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire
